### sv/ntp_seconds_to_local_date_dst_core_defines.svh
// ----------------------------------------------------------------------------
// ntp_seconds_to_local_date_dst_core_defines.svh
// Assertion macros shared by the calendar conversion core.
// ----------------------------------------------------------------------------
`ifndef NTP_SECONDS_TO_LOCAL_DATE_DST_CORE_DEFINES_SVH
`define NTP_SECONDS_TO_LOCAL_DATE_DST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define NTPLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// condition that must never be seen out of reset
`define NTPLD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define NTPLD_ASSERT(lbl, prop, msg)
`define NTPLD_NEVER(lbl, cond, msg)
`endif
`endif

### sv/ntpld_pkg.sv
// ----------------------------------------------------------------------------
// ntpld_pkg
// Types and constants shared by the calendar conversion controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package ntpld_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_DATA_W  = 5;

    localparam logic [10:0] YEAR_BASE      = 11'd1900;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN   = 12'd60;
    localparam logic [15:0] DAYS_PER_WEEK  = 16'd7;
    localparam logic [3:0]  MONTH_DEC      = 4'd11;

    // reciprocals for the constant divisions, each exact over its input range
    // days:    (secs >> 7) * RECIP_DAY >> 35, 25-bit operand, divides by 675
    // weekday: days * RECIP_WEEK >> 19, 16-bit operand, divides by 7
    // hours:   (sod >> 4) * RECIP_HOUR >> 21, 13-bit operand, divides by 225
    // minutes: (soh >> 2) * RECIP_MIN >> 14, 10-bit operand, divides by 15
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam logic [16:0] RECIP_WEEK = 17'd74899;
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_UTC_OFFSET = 1'b0,
        CFG_DST_ENABLE = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_DIV_DAY,
        S_TAKE_DAY,
        S_DIV_WD,
        S_TAKE_WD,
        S_DIV_HR,
        S_TAKE_HR,
        S_DIV_MIN,
        S_TAKE_MIN,
        S_YEAR,
        S_MONTH,
        S_EMIT
    } state_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_ADD,
        CMD_DIV_DAY,
        CMD_TAKE_DAY,
        CMD_DIV_WD,
        CMD_TAKE_WD,
        CMD_DIV_HR,
        CMD_TAKE_HR,
        CMD_DIV_MIN,
        CMD_TAKE_MIN,
        CMD_YEAR_STEP,
        CMD_MONTH_STEP,
        CMD_EMIT
    } dp_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_busy;
    } dp_status_t;

endpackage

### sv/ntpld_ctrl.sv
// ----------------------------------------------------------------------------
// ntpld_ctrl
// Sequencer for the conversion: offset add, four reciprocal divisions with
// their remainders, year and month stepping, then hand-off to the output
// register.
// ----------------------------------------------------------------------------
module ntpld_ctrl
    import ntpld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd        = CMD_ADD;
                state_next = S_DIV_DAY;
            end
            S_DIV_DAY: begin
                cmd        = CMD_DIV_DAY;
                state_next = S_TAKE_DAY;
            end
            S_TAKE_DAY: begin
                cmd        = CMD_TAKE_DAY;
                state_next = S_DIV_WD;
            end
            S_DIV_WD: begin
                cmd        = CMD_DIV_WD;
                state_next = S_TAKE_WD;
            end
            S_TAKE_WD: begin
                cmd        = CMD_TAKE_WD;
                state_next = S_DIV_HR;
            end
            S_DIV_HR: begin
                cmd        = CMD_DIV_HR;
                state_next = S_TAKE_HR;
            end
            S_TAKE_HR: begin
                cmd        = CMD_TAKE_HR;
                state_next = S_DIV_MIN;
            end
            S_DIV_MIN: begin
                cmd        = CMD_DIV_MIN;
                state_next = S_TAKE_MIN;
            end
            S_TAKE_MIN: begin
                cmd        = CMD_TAKE_MIN;
                state_next = S_YEAR;
            end
            S_YEAR: begin
                if (status.year_done) begin
                    state_next = S_MONTH;
                end else begin
                    cmd = CMD_YEAR_STEP;
                end
            end
            S_MONTH: begin
                if (status.month_done) begin
                    state_next = S_EMIT;
                end else begin
                    cmd = CMD_MONTH_STEP;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!status.out_busy) begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/ntpld_datapath.sv
// ----------------------------------------------------------------------------
// ntpld_datapath
// Configuration, summer flag, offset multiply, reciprocal-multiply splits
// of the local seconds, year and month stepping, and the output register.
// ----------------------------------------------------------------------------
module ntpld_datapath
    import ntpld_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    // leap rule, valid for the reachable years 1900..2036
    function automatic logic leap_year(input logic [10:0] y);
        leap_year = (y[1:0] == 2'b00) && (y != YEAR_BASE);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd1:    month_len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    endfunction

    // EU summer rule at day granularity; month 1..12, weekday 1..7
    function automatic logic eu_summer(input logic [3:0] m, input logic [4:0] d,
                                       input logic [2:0] wd);
        logic [5:0] left;
        logic       later;
        left  = 6'd31 - {1'b0, d};
        later = (left + {3'b000, wd}) >= 6'd7;
        if (m == 4'd3 || m == 4'd10) begin
            if (left >= 6'd7)       eu_summer = (m == 4'd10);
            else if (wd == 3'd7)    eu_summer = (m == 4'd3);
            else if (m == 4'd3)     eu_summer = !later;
            else                    eu_summer = later;
        end else begin
            eu_summer = (m > 4'd3) && (m < 4'd10);
        end
    endfunction

    // control state
    logic [4:0]  offset_reg, offset_next;
    logic        dst_en_reg, dst_en_next;
    logic        summer_reg, summer_next;
    logic        valid_reg, valid_next;
    // payload
    logic [31:0] utc_reg, utc_next;
    logic signed [17:0] prod_reg, prod_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [15:0] quo_reg, quo_next;
    logic [16:0] sod_reg, sod_next;
    logic [11:0] soh_reg, soh_next;
    logic [15:0] days_reg, days_next;
    logic [2:0]  wd_reg, wd_next;
    logic [4:0]  hours_reg, hours_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [10:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    logic signed [17:0] off_ext;
    logic [31:0] local_sum;
    logic [50:0] day_prod;
    logic [32:0] wk_prod;
    logic [26:0] hr_prod;
    logic [20:0] mn_prod;
    logic [31:0] day_rem;
    logic [15:0] wk_rem;
    logic [16:0] hr_rem;
    logic [11:0] mn_rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [3:0]  mon_out;
    logic [4:0]  day_out;
    logic        summer_new;

    // reciprocal quotients, remainders, year and month lengths
    always_comb begin
        off_ext   = 18'(signed'(offset_reg)) + 18'(summer_reg);
        local_sum = utc_reg + {{14{prod_reg[17]}}, prod_reg};
        day_prod  = 51'(dvd_reg[31:7]) * 51'(RECIP_DAY);
        wk_prod   = 33'(days_reg) * 33'(RECIP_WEEK);
        hr_prod   = 27'(sod_reg[16:4]) * 27'(RECIP_HOUR);
        mn_prod   = 21'(soh_reg[11:2]) * 21'(RECIP_MIN);
        day_rem   = dvd_reg - 32'(quo_reg) * SECS_PER_DAY;
        wk_rem    = days_reg - quo_reg * DAYS_PER_WEEK;
        hr_rem    = sod_reg - 17'(quo_reg) * SECS_PER_HOUR;
        mn_rem    = soh_reg - 12'(quo_reg) * SECS_PER_MIN;
        leap      = leap_year(year_reg);
        ylen      = leap ? 9'd366 : 9'd365;
        mlen      = month_len(mon_reg, leap);
        mon_out   = mon_reg + 4'd1;
        day_out   = days_reg[4:0] + 5'd1;
        summer_new = dst_en_reg ? eu_summer(mon_out, day_out, wd_reg) : summer_reg;
    end

    assign status.year_done  = days_reg < {7'd0, ylen};
    assign status.month_done = (days_reg < {11'd0, mlen}) || (mon_reg == MONTH_DEC);
    assign status.out_busy   = valid_reg && !out_ready;

    // next-state logic
    always_comb begin
        offset_next = offset_reg;
        dst_en_next = dst_en_reg;
        summer_next = summer_reg;
        valid_next  = valid_reg && !out_ready;
        utc_next    = utc_reg;
        prod_next   = prod_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        sod_next    = sod_reg;
        soh_next    = soh_reg;
        days_next   = days_reg;
        wd_next     = wd_reg;
        hours_next  = hours_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        out_next    = out_reg;

        // take configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_UTC_OFFSET: offset_next = cfg_wdata;
                CFG_DST_ENABLE: dst_en_next = cfg_wdata[0];
                default: ;
            endcase
        end

        case (cmd)
            CMD_CAPTURE: begin
                utc_next  = in_data;
                prod_next = off_ext * 18'sd3600;
            end
            CMD_ADD: begin
                dvd_next = local_sum;
            end
            CMD_DIV_DAY: begin
                quo_next = day_prod[50:35];
            end
            CMD_TAKE_DAY: begin
                days_next = quo_reg;
                sod_next  = day_rem[16:0];
            end
            CMD_DIV_WD: begin
                quo_next = {2'd0, wk_prod[32:19]};
            end
            CMD_TAKE_WD: begin
                wd_next   = wk_rem[2:0] + 3'd1;
                year_next = YEAR_BASE;
            end
            CMD_DIV_HR: begin
                quo_next = {10'd0, hr_prod[26:21]};
            end
            CMD_TAKE_HR: begin
                hours_next = quo_reg[4:0];
                soh_next   = hr_rem[11:0];
            end
            CMD_DIV_MIN: begin
                quo_next = {9'd0, mn_prod[20:14]};
            end
            CMD_TAKE_MIN: begin
                min_next = quo_reg[5:0];
                sec_next = mn_rem[5:0];
                mon_next = '0;
            end
            CMD_YEAR_STEP: begin
                days_next = days_reg - {7'd0, ylen};
                year_next = year_reg + 11'd1;
            end
            CMD_MONTH_STEP: begin
                days_next = days_reg - {11'd0, mlen};
                mon_next  = mon_reg + 4'd1;
            end
            CMD_EMIT: begin
                summer_next = summer_new;
                valid_next  = 1'b1;
                out_next    = {7'd0, summer_new, sec_reg, min_reg, hours_reg,
                               wd_reg, day_out, mon_out, year_reg};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            dst_en_reg <= 1'b0;
            summer_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            dst_en_reg <= dst_en_next;
            summer_reg <= summer_next;
            valid_reg  <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        utc_reg   <= utc_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        sod_reg   <= sod_next;
        soh_reg   <= soh_next;
        days_reg  <= days_next;
        wd_reg    <= wd_next;
        hours_reg <= hours_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        year_reg  <= year_next;
        mon_reg   <= mon_next;
        out_reg   <= out_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

### sv/ntp_seconds_to_local_date_dst_core.sv
// ----------------------------------------------------------------------------
// ntp_seconds_to_local_date_dst_core
// UTC seconds since 1900 to local calendar date and time with EU summer time.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per conversion, tdata = UTC seconds since 1 Jan 1900.
//   m_axis: one result item per input item, local date and time fields.
//   cfg: plain write port, index 0 zone offset (signed hours), index 1 DST
//   enable; write only while no conversion is in flight.
// Conversion steps:
//   The local seconds are split by reciprocal multiplication into days,
//   weekday, hours and minutes (a multiply step and a remainder step
//   each), then one year and one month are stepped per cycle. The next
//   item is taken on the cycle after the current one has been handed to
//   the output register.
// Reset:
//   aresetn clears the zone offset, DST enable, summer flag and output
//   valid; the block is ready for an item on the first cycle after reset.
// Stall:
//   The result holds in the output register while m_axis_tready is low;
//   a new item is accepted and converted meanwhile, and waits for the slot.
// ----------------------------------------------------------------------------
`include "ntp_seconds_to_local_date_dst_core_defines.svh"

module ntp_seconds_to_local_date_dst_core
    import ntpld_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] utc_seconds
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [10:0] year, [14:11] month, [19:15] day, [22:20] weekday,
    // [27:23] hours, [33:28] minutes, [39:34] seconds_of_minute,
    // [40] summer_now, [47:41] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_accept;
    logic       month_bad;

    ntpld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ntpld_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign month_bad = (m_axis_tdata[14:11] == 4'd0) || (m_axis_tdata[14:11] > 4'd12);

    // one item at a time: no accept on the cycle after an accept
    `NTPLD_ASSERT(a_single_item, in_accept |=> !s_axis_tready, "item accepted while busy")
    // result month in 1..12
    `NTPLD_NEVER(a_month_range, m_axis_tvalid && month_bad, "month out of range")
    // result weekday in 1..7
    `NTPLD_NEVER(a_weekday_range, m_axis_tvalid && m_axis_tdata[22:20] == 3'd0, "weekday zero")

endmodule
